// ===== sv/hrsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_pkg: shared types and constants of the request stream parser
// Character codes, byte role codes and the classified byte record that moves
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package hrsp_pkg;

  // Characters the parser reacts to
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Header name that carries the body length, first character in the top byte
  localparam int unsigned NAME_LEN = 14;
  localparam logic [NAME_LEN-1:0][7:0] LEN_NAME = "Content-Length";

  // Name match progress: count of matched bytes, or the mismatch mark
  localparam logic [3:0] MATCH_DONE = 4'd14;
  localparam logic [3:0] MATCH_FAIL = 4'd15;

  // Byte roles; the section register uses the same codes
  localparam logic [2:0] ROLE_METHOD = 3'd0;
  localparam logic [2:0] ROLE_URI    = 3'd1;
  localparam logic [2:0] ROLE_PROTO  = 3'd2;
  localparam logic [2:0] ROLE_KEY    = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;
  localparam logic [2:0] ROLE_DELIM  = 3'd5;
  localparam logic [2:0] ROLE_BODY   = 3'd6;
  localparam logic [2:0] ROLE_EXCESS = 3'd7;

  // Classified request byte
  typedef struct packed {
    logic [7:0]          data;
    logic                new_request;
    logic                is_cr;
    logic                is_lf;
    logic                is_space;
    logic                is_colon;
    logic                is_digit;
    logic [3:0]          digit;
    logic [NAME_LEN-1:0] name_hit;
  } hrsp_item_t;

endpackage

// ===== sv/hrsp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_in_if: request byte channel
// Valid/ready channel carrying one raw byte and the new-request mark.
// ----------------------------------------------------------------------------
interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       new_request;

  modport source (output valid, output byte_in, output new_request, input ready);
  modport sink   (input valid, input byte_in, input new_request, output ready);
endinterface

// ===== sv/hrsp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_out_if: tagged byte channel
// Valid/ready channel carrying a byte, its role, completion flags and length.
// ----------------------------------------------------------------------------
interface hrsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [2:0]  byte_role;
  logic        header_done;
  logic        request_done;
  logic [31:0] body_length;

  modport source (output valid, output byte_out, output byte_role, output header_done,
                  output request_done, output body_length, input ready);
  modport sink   (input valid, input byte_out, input byte_role, input header_done,
                  input request_done, input body_length, output ready);
endinterface

// ===== sv/http_request_stream_parser.sv =====
// Path: a request passes through the classify register at acceptance, then a
// queue entry, then the result register, before it appears on the output.
// Throughput: one byte per cycle while the sink is ready; the parser step in the
// back end sets the rate, and the two-entry queue absorbs stalls on either side.
// Reset: rst_ni clears all parsing state and empties every stage at once.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_stream_parser: HTTP request byte tagger
// Tags each request byte with its role, flags the end of the header and the
// end of the request, and reports the parsed content length.
// ----------------------------------------------------------------------------
module http_request_stream_parser #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrsp_in_if.sink     req_i,
  hrsp_out_if.source  rsp_o
);
  import hrsp_pkg::*;

  logic       push_valid;
  logic       push_ready;
  hrsp_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  hrsp_item_t pop_item;

  hrsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  hrsp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  hrsp_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_ready_o (pop_ready),
    .q_item_i  (pop_item),
    .rsp_o     (rsp_o)
  );

  // End of header is only ever flagged on a delimiting LF
  a_hdone_on_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.header_done |->
      (rsp_o.byte_out == CH_LF) && (rsp_o.byte_role == ROLE_DELIM))
    else $error("header end flagged on a byte other than a delimiting LF");

  // Completion comes at the header end or on a body byte
  a_rdone_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.request_done |->
      rsp_o.header_done || (rsp_o.byte_role == ROLE_BODY))
    else $error("request completion flagged outside header end or body");

  // A classified request held back by a full queue stays in place
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |=> push_valid && $stable(push_item))
    else $error("front stage lost or changed a request while the queue was full");

endmodule

// ===== sv/hrsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_front: request byte intake and classification
// Accepts a request, decodes its character class and name matches into a
// register, and offers the record to the queue.
// ----------------------------------------------------------------------------
module hrsp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  hrsp_in_if.sink             req_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output hrsp_pkg::hrsp_item_t push_item_o
);
  import hrsp_pkg::*;

  logic       valid_q;
  hrsp_item_t item_q;
  hrsp_item_t item_d;
  logic       take;

  // Classify the incoming byte
  always_comb begin
    item_d             = '0;
    item_d.data        = req_i.byte_in;
    item_d.new_request = req_i.new_request;
    item_d.is_cr       = (req_i.byte_in == CH_CR);
    item_d.is_lf       = (req_i.byte_in == CH_LF);
    item_d.is_space    = (req_i.byte_in == CH_SPACE);
    item_d.is_colon    = (req_i.byte_in == CH_COLON);
    item_d.is_digit    = (req_i.byte_in >= CH_ZERO) && (req_i.byte_in <= CH_NINE);
    item_d.digit       = req_i.byte_in[3:0];
    for (int i = 0; i < NAME_LEN; i++) begin
      item_d.name_hit[i] = (req_i.byte_in == LEN_NAME[NAME_LEN-1-i]);
    end
  end

  assign req_i.ready = !valid_q || push_ready_i;
  assign take        = req_i.valid && req_i.ready;

  // Hold the record until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

// ===== sv/hrsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_fifo: two-entry queue between front and back end
// Decouples classification from the parsing state so each side stalls alone.
// ----------------------------------------------------------------------------
module hrsp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  hrsp_pkg::hrsp_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output hrsp_pkg::hrsp_item_t pop_item_o
);
  import hrsp_pkg::*;

  localparam int unsigned Depth = 2;

  hrsp_item_t  entry_q [Depth];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        push;
  logic        pop;

  assign push_ready_o = (count_q != 2'(Depth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Store the request record
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/hrsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_back: parsing state and result register
// Tracks the request section, header name match and body length, tags each
// byte and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module hrsp_back #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  hrsp_pkg::hrsp_item_t q_item_i,
  hrsp_out_if.source           rsp_o
);
  import hrsp_pkg::*;

  localparam logic [LENGTH_WIDTH-1:0] LenMax = '1;

  // Parsing state
  logic [2:0]              section_q, section_d;
  logic [23:0]             recent_q, recent_d;
  logic [3:0]              match_q, match_d;
  logic                    len_line_q, len_line_d;
  logic                    len_seen_q, len_seen_d;
  logic [LENGTH_WIDTH-1:0] len_val_q, len_val_d;
  logic [LENGTH_WIDTH-1:0] body_cnt_q, body_cnt_d;

  // Per-byte result
  logic [2:0]              role;
  logic                    hdone;
  logic                    rdone;
  logic [LENGTH_WIDTH+3:0] prod;
  logic [31:0]             len_out;
  logic                    fire;

  // Result register
  logic                    out_valid_q;
  logic [7:0]              out_byte_q;
  logic [2:0]              out_role_q;
  logic                    out_hdone_q;
  logic                    out_rdone_q;
  logic [31:0]             out_len_q;

  assign q_ready_o = !out_valid_q || rsp_o.ready;
  assign fire      = q_valid_i && q_ready_o;

  // Step the parser over one byte
  always_comb begin
    section_d  = section_q;
    recent_d   = recent_q;
    match_d    = match_q;
    len_line_d = len_line_q;
    len_seen_d = len_seen_q;
    len_val_d  = len_val_q;
    body_cnt_d = body_cnt_q;
    hdone      = 1'b0;
    rdone      = 1'b0;
    prod       = '0;

    // Drop all state at the start of a new request
    if (q_item_i.new_request) begin
      section_d  = ROLE_METHOD;
      recent_d   = '0;
      match_d    = '0;
      len_line_d = 1'b0;
      len_seen_d = 1'b0;
      len_val_d  = '0;
      body_cnt_d = '0;
    end

    role = section_d;

    if (section_d == ROLE_EXCESS) begin
      role = ROLE_EXCESS;
    end else if (section_d == ROLE_BODY) begin
      role = ROLE_BODY;
      if (body_cnt_d != LenMax) begin
        body_cnt_d = body_cnt_d + 1'b1;
      end
      if (body_cnt_d == len_val_d) begin
        rdone     = 1'b1;
        section_d = ROLE_EXCESS;
      end
    end else if (q_item_i.is_cr) begin
      role       = ROLE_DELIM;
      len_line_d = 1'b0;
    // The preceding byte counts even across a new-request clear
    end else if (q_item_i.is_lf && (recent_q[7:0] == CH_CR)) begin
      role = ROLE_DELIM;
      if (recent_d == {CH_CR, CH_LF, CH_CR}) begin
        // Blank line closes the header
        hdone = 1'b1;
        if (len_val_d == '0) begin
          rdone     = 1'b1;
          section_d = ROLE_EXCESS;
        end else begin
          section_d  = ROLE_BODY;
          body_cnt_d = '0;
        end
      end else begin
        section_d = ROLE_KEY;
        match_d   = '0;
      end
    end else begin
      if ((section_d == ROLE_METHOD) && q_item_i.is_space) begin
        role      = ROLE_DELIM;
        section_d = ROLE_URI;
      end else if ((section_d == ROLE_URI) && q_item_i.is_space) begin
        role      = ROLE_DELIM;
        section_d = ROLE_PROTO;
      end else if (section_d == ROLE_KEY) begin
        // Match the length header name
        if (match_d < MATCH_DONE) begin
          if (q_item_i.name_hit[match_d]) begin
            match_d = match_d + 4'd1;
            if ((match_d == MATCH_DONE) && !len_seen_d) begin
              len_seen_d = 1'b1;
              len_line_d = 1'b1;
            end
          end else begin
            match_d = MATCH_FAIL;
          end
        end
        if (q_item_i.is_colon) begin
          role      = ROLE_DELIM;
          section_d = ROLE_VALUE;
        end
      end
      // Accumulate length digits, saturating
      if (len_line_d && ((section_d == ROLE_KEY) || (section_d == ROLE_VALUE))
          && q_item_i.is_digit) begin
        prod = ({4'b0, len_val_d} << 3) + ({4'b0, len_val_d} << 1)
             + (LENGTH_WIDTH+4)'(q_item_i.digit);
        if (|prod[LENGTH_WIDTH+3:LENGTH_WIDTH]) begin
          len_val_d = LenMax;
        end else begin
          len_val_d = prod[LENGTH_WIDTH-1:0];
        end
      end
    end

    recent_d = {recent_d[15:0], q_item_i.data};
  end

  // Clamp the reported length to 32 bits, or zero-extend a narrower one
  if (LENGTH_WIDTH > 32) begin : g_clamp
    assign len_out = (|len_val_d[LENGTH_WIDTH-1:32]) ? 32'hFFFF_FFFF : len_val_d[31:0];
  end else begin : g_extend
    assign len_out = 32'(len_val_d);
  end

  // Advance the parsing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q  <= ROLE_METHOD;
      recent_q   <= '0;
      match_q    <= '0;
      len_line_q <= 1'b0;
      len_seen_q <= 1'b0;
      len_val_q  <= '0;
      body_cnt_q <= '0;
    end else if (fire) begin
      section_q  <= section_d;
      recent_q   <= recent_d;
      match_q    <= match_d;
      len_line_q <= len_line_d;
      len_seen_q <= len_seen_d;
      len_val_q  <= len_val_d;
      body_cnt_q <= body_cnt_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_ready_o) begin
      out_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q  <= q_item_i.data;
      out_role_q  <= role;
      out_hdone_q <= hdone;
      out_rdone_q <= rdone;
      out_len_q   <= len_out;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.byte_out     = out_byte_q;
  assign rsp_o.byte_role    = out_role_q;
  assign rsp_o.header_done  = out_hdone_q;
  assign rsp_o.request_done = out_rdone_q;
  assign rsp_o.body_length  = out_len_q;

endmodule
